[hw/rtl/cstg_pkg.sv]
package cstg_pkg;

    localparam int SampleRateDef   = 48000;
    localparam int PulseSamplesDef = 480;
    localparam int MaxPeriodsDef   = 64;

    localparam int LevelW = 16;
    localparam int CfgW   = 16;
    localparam int CfgIdxW = 3;
    localparam int EdgeW  = 24;
    localparam int StepW  = 7;
    localparam int PulseW = 16;
    localparam int EaseW  = 13;

    localparam logic [CfgIdxW-1:0] RegInit   = 3'd0;
    localparam logic [CfgIdxW-1:0] RegTarget = 3'd1;
    localparam logic [CfgIdxW-1:0] RegDur    = 3'd2;
    localparam logic [CfgIdxW-1:0] RegCurve  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegDelay  = 3'd4;
    localparam logic [CfgIdxW-1:0] RegEaseIn = 3'd5;
    localparam logic [CfgIdxW-1:0] RegEaseOut = 3'd6;
    localparam logic [CfgIdxW-1:0] RegChain  = 3'd7;

    localparam logic [1:0] CurveRamp = 2'd0;
    localparam logic [1:0] CurveBack = 2'd1;
    localparam logic [1:0] CurveStep = 2'd2;
    localparam logic [1:0] CurveTri  = 2'd3;

    typedef struct packed {
        logic clock_rise;
        logic reset_rise;
        logic fire_rise;
    } t_in;

    typedef struct packed {
        logic signed [LevelW-1:0] level;
        logic                     end_pulse;
        logic                     busy_res;
    } t_out;

    // datapath commands and status
    typedef struct packed {
        logic start;     // latch item, run phase logic
        logic div_go;    // start t division
        logic mix_go;    // shape + mix of computed t
        logic fin;       // commit level
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic mix_done;
        logic need_calc; // level update needed for this item
    } t_sts;

    function automatic logic [5:0] delay_lut(input logic [2:0] sel);
        unique case (sel)
            3'd0: delay_lut = 6'd0;
            3'd1: delay_lut = 6'd1;
            3'd2: delay_lut = 6'd2;
            3'd3: delay_lut = 6'd4;
            3'd4: delay_lut = 6'd8;
            3'd5: delay_lut = 6'd16;
            default: delay_lut = 6'd32;
        endcase
    endfunction

endpackage

[hw/rtl/cstg_if.sv]
interface cstg_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/cstg_ctrl.sv]
module cstg_ctrl
    import cstg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_DIV  = 5'b00100,
        S_MIX  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.start = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.need_calc) begin
                    o_cmd.div_go = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.fin = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_DIV: if (i_sts.div_done) begin
                o_cmd.mix_go = 1'b1;
                n_state = S_MIX;
            end
            S_MIX: if (i_sts.mix_done) begin
                o_cmd.fin = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_valid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken with result pending");
    a_start_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == S_EVAL))
        else $error("start without evaluation");
endmodule

[hw/rtl/cstg_dp.sv]
module cstg_dp
    import cstg_pkg::*;
#(
    parameter int SAMPLE_RATE   = SampleRateDef,
    parameter int PULSE_SAMPLES = PulseSamplesDef,
    parameter int MAX_PERIODS   = MaxPeriodsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_data,
    input  t_in                i_item,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output t_out               o_res
);
    localparam int PerMinI = (SAMPLE_RATE / 2000) < 1 ? 1 : (SAMPLE_RATE / 2000);
    localparam logic [EdgeW-1:0] PerMin  = EdgeW'(PerMinI);
    localparam logic [EdgeW-1:0] PerMax  = EdgeW'(15 * SAMPLE_RATE);
    localparam logic [EdgeW-1:0] PerRst  = EdgeW'(SAMPLE_RATE / 2);
    localparam logic [EdgeW-1:0] EdgeMax = {EdgeW{1'b1}};
    localparam logic [StepW-1:0] MaxP    = StepW'(MAX_PERIODS);
    localparam logic [PulseW-1:0] PulseN = PulseW'(PULSE_SAMPLES);
    localparam int NumW  = StepW + EdgeW + 16; // 47
    localparam int DenW  = EdgeW + StepW;      // 31
    localparam int QW    = 17;

    // configuration
    logic signed [LevelW-1:0] r_init, r_target;
    logic [6:0]  r_dur;
    logic [1:0]  r_curve;
    logic [2:0]  r_dsel;
    logic [10:0] r_ein, r_eout;
    logic        r_chain;

    // state
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001, PH_ARMED = 4'b0010, PH_DELAY = 4'b0100, PH_TRANS = 4'b1000
    } t_phase;
    t_phase r_phase;
    logic [5:0]  r_dleft;
    logic [StepW-1:0] r_pdone, r_steps;
    logic [EdgeW-1:0] r_since, r_pmeas, r_plat;
    logic        r_have;
    logic signed [LevelW-1:0] r_start, r_end, r_level;
    logic signed [EaseW-1:0]  r_elin, r_equad;
    logic [PulseW-1:0] r_pleft;

    // working registers
    logic [NumW-1:0] r_rem;
    logic [DenW-1:0] r_den;
    logic [QW-1:0]   r_q;
    logic [5:0]      r_bit;
    logic            r_div_busy, r_div_done;
    logic            r_need;
    logic [2:0]      r_mstep;
    logic [16:0]     r_t;
    logic [16:0]     r_s;
    logic signed [31:0] r_acc;
    logic            r_mix_busy, r_mix_done;
    logic            r_pulse_out;

    function automatic logic signed [LevelW-1:0] sat_cfg(input logic [CfgW-1:0] v);
        logic signed [LevelW-1:0] x;
        x = $signed(v);
        if (x > 16'sd32000) x = 16'sd32000;
        if (x < -16'sd32000) x = -16'sd32000;
        return x;
    endfunction

    // next-state of the sample step (phase logic, combinational)
    t_phase n_phase;
    logic [5:0] n_dleft;
    logic [StepW-1:0] n_pdone, n_steps;
    logic [EdgeW-1:0] n_since, n_pmeas, n_plat;
    logic n_have, n_begin, n_end, n_stepcalc;
    logic [EdgeW+11:0] near_a;
    logic near;
    logic [5:0] dly;
    logic [StepW-1:0] stp;

    always_comb begin
        n_phase = r_phase;
        n_dleft = r_dleft;
        n_pdone = r_pdone;
        n_steps = r_steps;
        n_since = r_since;
        n_pmeas = r_pmeas;
        n_plat  = r_plat;
        n_have  = r_have;
        n_begin = 1'b0;
        n_end   = 1'b0;
        n_stepcalc = 1'b0;
        dly = delay_lut(r_dsel);
        stp = (r_dur == '0) ? StepW'(1) : r_dur;
        if (stp > MaxP) stp = MaxP;
        if (MaxP > StepW'(dly)) begin
            if (stp > MaxP - StepW'(dly)) stp = MaxP - StepW'(dly);
        end else begin
            stp = StepW'(1);
        end
        if (i_item.reset_rise) begin
            n_phase = PH_IDLE;
            n_dleft = '0;
        end
        if (i_item.clock_rise) begin
            if (r_have) begin
                n_pmeas = r_since < PerMin ? PerMin : (r_since > PerMax ? PerMax : r_since);
            end
            n_have = 1'b1;
            n_since = '0;
            unique case (n_phase)
                PH_ARMED: if (n_dleft != '0) n_phase = PH_DELAY; else n_begin = 1'b1;
                PH_DELAY: begin
                    if (n_dleft != '0) n_dleft = n_dleft - 6'd1;
                    if (n_dleft == '0) n_begin = 1'b1;
                end
                PH_TRANS: begin
                    n_pdone = r_pdone + StepW'(1);
                    if (n_pdone >= r_steps) n_end = 1'b1;
                    else if (r_curve == CurveStep) n_stepcalc = 1'b1;
                end
                default: ;
            endcase
        end else if (r_since < EdgeMax) begin
            n_since = r_since + EdgeW'(1);
        end
        if (n_end) n_phase = PH_IDLE;
        if (n_begin) n_phase = PH_TRANS;
        near_a = {12'd0, n_since} * 36'd2000;
        near = r_chain && n_have && near_a <= (EdgeW+12)'(SAMPLE_RATE)
               && ({n_since, 2'b00} <= {2'b00, n_pmeas});
        if (i_item.fire_rise && n_phase == PH_IDLE) begin
            n_dleft = dly;
            if (i_item.clock_rise || near) begin
                if (dly != '0) n_phase = PH_DELAY;
                else begin
                    n_begin = 1'b1;
                    n_phase = PH_TRANS;
                end
            end else begin
                n_phase = PH_ARMED;
            end
        end
        if (n_begin) begin
            n_pdone = '0;
            n_plat  = n_pmeas;
            n_steps = stp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0; r_target <= '0; r_dur <= 7'd8; r_curve <= CurveRamp;
            r_dsel <= '0; r_ein <= '0; r_eout <= '0; r_chain <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegInit:    r_init <= sat_cfg(i_cfg_data);
                RegTarget:  r_target <= sat_cfg(i_cfg_data);
                RegDur:     r_dur <= i_cfg_data[6:0];
                RegCurve:   r_curve <= i_cfg_data[1:0];
                RegDelay:   r_dsel <= (i_cfg_data[2:0] > 3'd6) ? 3'd6 : i_cfg_data[2:0];
                RegEaseIn:  r_ein <= (i_cfg_data[10:0] > 11'd1024) ? 11'd1024 : i_cfg_data[10:0];
                RegEaseOut: r_eout <= (i_cfg_data[10:0] > 11'd1024) ? 11'd1024 : i_cfg_data[10:0];
                RegChain:   r_chain <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // shape evaluation sequence on r_t -> r_acc (ease) -> r_s, then mix -> r_level
    logic [16:0] tt;
    logic        tri_hi;
    logic signed [30:0] inner;
    logic [47:0] prod;
    logic [16:0] shp;
    logic signed [17:0] diff;
    logic signed [35:0] mixp;
    logic signed [LevelW-1:0] mixv;

    always_comb begin
        tri_hi = (r_curve == CurveTri) && (r_t >= 17'd32768);
        if (r_curve != CurveTri) tt = r_t;
        else if (!tri_hi) tt = {r_t[15:0], 1'b0};
        else tt = {r_t[15:0], 1'b0} - 17'd65536;
        inner = $signed({r_elin, 16'd0}) + $signed(r_equad) * $signed({1'b0, tt});
        prod = 48'(r_acc) * 48'(tt);
        shp = (prod[47:26] > 22'd65536) ? 17'd65536 : prod[42:26];
        diff = 18'(r_end) - 18'(r_start);
        mixp = diff * $signed({1'b0, r_s}) + 36'sd32768;
        mixv = r_start + 16'(mixp >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_dleft <= '0; r_pdone <= '0; r_steps <= 7'd8;
            r_since <= '0; r_have <= 1'b0; r_pmeas <= PerRst; r_plat <= PerRst;
            r_start <= '0; r_end <= '0; r_elin <= 13'sd1024; r_equad <= '0;
            r_level <= '0; r_pleft <= '0; r_need <= 1'b0;
            r_div_busy <= 1'b0; r_div_done <= 1'b0; r_mix_busy <= 1'b0;
            r_mix_done <= 1'b0; r_pulse_out <= 1'b0;
        end else begin
            r_div_done <= 1'b0;
            r_mix_done <= 1'b0;
            if (i_cmd.start) begin
                r_phase <= n_phase; r_dleft <= n_dleft; r_pdone <= n_pdone;
                r_steps <= n_steps; r_since <= n_since; r_have <= n_have;
                r_pmeas <= n_pmeas; r_plat <= n_plat;
                if (i_item.reset_rise) r_level <= r_init;
                if (n_end) begin
                    r_level <= (r_curve == CurveBack || r_curve == CurveTri)
                               ? r_start : r_end;
                    r_pleft <= PulseN;
                end else if (i_item.reset_rise) begin
                    r_pleft <= '0;
                end
                if (n_begin) begin
                    r_start <= r_init; r_end <= r_target;
                    r_elin  <= 13'sd1024 - $signed({2'b0, r_ein}) + $signed({2'b0, r_eout});
                    r_equad <= $signed({2'b0, r_ein}) - $signed({2'b0, r_eout});
                end
                // stepped: t = pdone*65536/steps ; begin: t = 0
                r_need <= (n_phase == PH_TRANS) &&
                          ((r_curve == CurveStep) ? (n_begin || n_stepcalc)
                                                  : (n_since <= n_plat));
            end
            if (i_cmd.div_go) begin
                if (r_curve == CurveStep) begin
                    r_rem <= NumW'(r_pdone) << 16;
                    r_den <= DenW'(r_steps);
                end else begin
                    r_rem <= (NumW'(r_pdone) * NumW'(r_plat) + NumW'(r_since)) << 16;
                    r_den <= DenW'(r_plat) * DenW'(r_steps);
                end
                r_q <= '0;
                r_bit <= 6'd17;
                r_div_busy <= 1'b1;
            end else if (r_div_busy) begin
                // restoring division, one quotient bit per cycle (q < 2^17)
                if (r_bit == '0) begin
                    r_div_busy <= 1'b0;
                    r_div_done <= 1'b1;
                    r_t <= (r_q > 17'd65536) ? 17'd65536 : r_q;
                end else begin
                    if ((r_rem >> (r_bit - 6'd1)) >= NumW'(r_den)) begin
                        r_rem <= r_rem - (NumW'(r_den) << (r_bit - 6'd1));
                        r_q <= r_q | (QW'(1) << (r_bit - 6'd1));
                    end
                    r_bit <= r_bit - 6'd1;
                end
            end
            if (i_cmd.mix_go) begin
                r_mstep <= 3'd0;
                r_mix_busy <= 1'b1;
            end else if (r_mix_busy) begin
                unique case (r_mstep)
                    3'd0: r_acc <= (inner < 0) ? 32'sd0 : 32'(inner);
                    3'd1: r_s <= (r_curve == CurveStep) ? shp
                                 : (tri_hi ? 17'd65536 - shp : shp);
                    3'd2: begin
                        r_mix_busy <= 1'b0;
                        r_mix_done <= 1'b1;
                    end
                    default: ;
                endcase
                r_mstep <= r_mstep + 3'd1;
            end
            if (i_cmd.fin) begin
                if (r_need) r_level <= mixv;
                r_pulse_out <= (r_pleft != '0);
                if (r_pleft != '0) r_pleft <= r_pleft - PulseW'(1);
            end
        end
    end

    assign o_sts.div_done  = r_div_done;
    assign o_sts.mix_done  = r_mix_done;
    assign o_sts.need_calc = r_need;
    assign o_res.level     = r_level;
    assign o_res.end_pulse = r_pulse_out;
    assign o_res.busy_res  = (r_phase == PH_DELAY) || (r_phase == PH_TRANS);

    a_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TRANS |-> (r_steps != '0 && r_steps <= MaxP))
        else $error("step count out of range");
    a_div_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_div_busy && r_mix_busy))
        else $error("divider and mixer both busy");
    a_plat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plat >= PerMin)
        else $error("latched period below minimum");
endmodule

[hw/rtl/clock_synced_transition_generator.sv]
// channel  | dir | payload                        | beat
// i_in     | in  | clock_rise, reset_rise, fire   | one sample
// o_out    | out | level, end_pulse, busy_res     | one per sample
// cfg      | in  | i_cfg_we, i_cfg_idx, i_cfg_data| one register write
// A sample without a level update skips the divider and the mixer; one with an update
// runs a bit-serial divider for progress and then a shape/mix unit.
// Reset clears phase, period estimate and registers to their defaults.
// One sample in flight; a result held by the sink stalls the input side.
module clock_synced_transition_generator
    import cstg_pkg::*;
#(
    parameter int SAMPLE_RATE   = SampleRateDef,
    parameter int PULSE_SAMPLES = PulseSamplesDef,
    parameter int MAX_PERIODS   = MaxPeriodsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_data,
    cstg_if.sink               i_in,
    cstg_if.source             o_out
);
    t_cmd cmd;
    t_sts sts;
    t_in  item;
    t_out res;

    assign item = i_in.data;

    cstg_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    cstg_dp #(
        .SAMPLE_RATE(SAMPLE_RATE), .PULSE_SAMPLES(PULSE_SAMPLES),
        .MAX_PERIODS(MAX_PERIODS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_item(item), .i_cmd(cmd), .o_sts(sts), .o_res(res)
    );

    assign o_out.data = res;
endmodule
